// ----- src/modular_exponentiation_core_defines.svh -----
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define MEXP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Checks that an antecedent is followed by its consequent in the next cycle.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation core.
package mexp_pkg;

    localparam int DATA_W           = 31;
    localparam int CNT_W            = $clog2(DATA_W);
    localparam int EXP_BITS_DEFAULT = 31;
    localparam int MAX_EXP_BITS     = 64;

    localparam logic [DATA_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef logic [DATA_W-1:0] word_t;

    // Status of the shared modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// ----- src/modular_exponentiation_core.sv -----
// Top level of the modular exponentiation core: configuration, sequencer and result register.
//
//  Channel   Direction  Beat contents              Handshake
//  s_        in         s_base, s_exponent         s_valid / s_ready
//  m_        out        m_power                    m_valid / m_ready
//  cfg_      in         cfg_wr_data (modulus)      cfg_wr_en, no wait
//
//  Each modular multiply runs on one shared bit-serial unit that steps through 31 multiplier
//  bits. An item costs one reduction of the base, then per exponent bit a square and,
//  for a set bit, a multiply.
//  Reset loads the modulus 1000000007 and empties the block; no clearing pass is needed.
//  s_ready is high only while the sequencer is idle; a finished result may wait in the
//  output register while the next beat is taken, and m_ready low stalls only the final step.
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mexp_pkg::DATA_W-1:0]  s_base,
    input  logic [mexp_pkg::DATA_W-1:0]  s_exponent,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mexp_pkg::DATA_W-1:0]  m_power,
    input  logic                         cfg_wr_en,
    input  logic [mexp_pkg::DATA_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BASE = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    mexp_pkg::word_t modulus_reg;
    mexp_pkg::word_t m_eff_reg, m_eff_next;
    mexp_pkg::word_t r_reg, r_next;
    mexp_pkg::word_t b_reg, b_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic                out_valid_reg, out_valid_next;
    mexp_pkg::word_t     out_power_reg, out_power_next;

    logic                               accept;
    mexp_pkg::word_t                    m_eff_in;
    mexp_pkg::word_t                    one_mod;
    logic [mexp_pkg::MAX_EXP_BITS-1:0]  exp_wide;

    logic               mm_start;
    mexp_pkg::word_t    mm_a;
    mexp_pkg::word_t    mm_b;
    mexp_pkg::word_t    mm_mod;
    mexp_pkg::word_t    mm_product;
    mexp_pkg::mm_stat_t mm_stat;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_power = out_power_reg;

    // A zero modulus lies outside the legal range and behaves like a modulus of one.
    assign m_eff_in = (modulus_reg == '0) ? mexp_pkg::word_t'(1) : modulus_reg;
    assign one_mod  = (m_eff_in == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);

    // Only the low EXP_BITS exponent bits take part; wider settings see zeros on top.
    assign exp_wide = {{(mexp_pkg::MAX_EXP_BITS - mexp_pkg::DATA_W){1'b0}}, s_exponent};

    // The multiplier latches its modulus at start; in idle the fresh value is handed in.
    assign mm_mod = (state_reg == ST_IDLE) ? m_eff_in : m_eff_reg;

    always_comb begin
        state_next     = state_reg;
        m_eff_next     = m_eff_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        out_power_next = out_power_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mm_start       = 1'b0;
        mm_a           = r_reg;
        mm_b           = r_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // The running value starts at 1 mod m, and the base is reduced by
                    // multiplying it with that same value on the shared unit.
                    m_eff_next = m_eff_in;
                    r_next     = one_mod;
                    e_next     = exp_wide[EXP_BITS-1:0];
                    i_next     = IDX_W'(EXP_BITS - 1);
                    mm_start   = 1'b1;
                    mm_a       = s_base;
                    mm_b       = one_mod;
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                if (mm_stat.done) begin
                    b_next     = mm_product;
                    mm_start   = 1'b1;
                    mm_a       = r_reg;
                    mm_b       = r_reg;
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    r_next = mm_product;
                    if (e_reg[EXP_BITS-1]) begin
                        mm_start   = 1'b1;
                        mm_a       = mm_product;
                        mm_b       = b_reg;
                        state_next = ST_MUL;
                    end else if (i_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        i_next     = i_reg - 1'b1;
                        e_next     = e_reg << 1;
                        mm_start   = 1'b1;
                        mm_a       = mm_product;
                        mm_b       = mm_product;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    r_next = mm_product;
                    if (i_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        i_next     = i_reg - 1'b1;
                        e_next     = e_reg << 1;
                        mm_start   = 1'b1;
                        mm_a       = mm_product;
                        mm_b       = mm_product;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_OUT: begin
                // Hand the result over once the output register is free or being emptied.
                if (!out_valid_reg || m_ready) begin
                    out_power_next = r_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= mexp_pkg::MODULUS_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_eff_reg     <= m_eff_next;
        r_reg         <= r_next;
        b_reg         <= b_next;
        e_reg         <= e_next;
        i_reg         <= i_next;
        out_power_reg <= out_power_next;
    end

    mexp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (mm_mod),
        .product (mm_product),
        .stat    (mm_stat)
    );

    `MEXP_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg == ST_BASE, "accepted beat not started")
    `MEXP_ASSERT_HOLDS(a_done_when_waiting, !mm_stat.done || state_reg == ST_BASE || state_reg == ST_SQR || state_reg == ST_MUL, "multiplier finished with no step waiting")
    `MEXP_ASSERT_HOLDS(a_running_reduced, state_reg == ST_IDLE || (r_reg < m_eff_reg), "running value not reduced")
    `MEXP_ASSERT_HOLDS(a_start_only_free, !(mm_start && mm_stat.busy), "multiplier restarted while busy")

endmodule

// ----- src/mexp_modmul.sv -----
// Bit-serial interleaved modular multiplier shared by all steps of the exponentiation.
`include "modular_exponentiation_core_defines.svh"

module mexp_modmul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  mexp_pkg::word_t  op_a,
    input  mexp_pkg::word_t  op_b,
    input  mexp_pkg::word_t  modulus,
    output mexp_pkg::word_t  product,
    output mexp_pkg::mm_stat_t stat
);

    localparam int SUM_W = mexp_pkg::DATA_W + 2;

    mexp_pkg::word_t acc_reg, acc_next;
    mexp_pkg::word_t a_reg, a_next;
    mexp_pkg::word_t b_reg;
    mexp_pkg::word_t m_reg;
    logic [mexp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] m_one;
    logic [SUM_W-1:0] m_two;
    logic [SUM_W-1:0] reduced;

    // One multiplier bit per cycle: acc = 2*acc + bit*b stays below 3m,
    // so at most one subtraction of m or 2m brings it back below m.
    always_comb begin
        sum   = {1'b0, acc_reg, 1'b0}
              + {2'b00, (a_reg[mexp_pkg::DATA_W-1] ? b_reg : mexp_pkg::word_t'(0))};
        m_one = {2'b00, m_reg};
        m_two = {1'b0, m_reg, 1'b0};
        priority if (sum >= m_two) begin
            reduced = sum - m_two;
        end else if (sum >= m_one) begin
            reduced = sum - m_one;
        end else begin
            reduced = sum;
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            a_next    = op_a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = reduced[mexp_pkg::DATA_W-1:0];
            a_next   = a_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mexp_pkg::CNT_W'(mexp_pkg::DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        if (start) begin
            b_reg <= op_b;
            m_reg <= modulus;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `MEXP_ASSERT_HOLDS(a_acc_reduced, !busy_reg || (acc_reg < m_reg), "accumulator left range")
    `MEXP_ASSERT_HOLDS(a_done_not_busy, !(done_reg && busy_reg), "done while still busy")
    `MEXP_ASSERT_NEXT(a_start_busy, start, busy_reg, "start did not launch the multiplier")

endmodule
